>>> hdl/tx_buffer_pool_allocator_assert.svh
// Assertion macros for the transmit buffer pool allocator.
// Both macros expect a clock named clock in scope; TXBP_ASSERT also expects an active-high reset named reset.
`ifndef TX_BUFFER_POOL_ALLOCATOR_ASSERT_SVH
`define TX_BUFFER_POOL_ALLOCATOR_ASSERT_SVH

// Checked only while the block is out of reset.
`define TXBP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define TXBP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/txbp_pkg.sv
// Shared constants and types for the transmit buffer pool allocator.
// No dependencies; every other file but txbp_search and the macro header imports it.
package txbp_pkg;

   localparam int unsigned POOL_COUNT_DEF   = 16;
   localparam int unsigned BUFFER_BYTES_DEF = 1536;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned BUF_IDX_W   = 4;
   localparam int unsigned IN_FLIGHT_W = 5;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED  = 3'd0,
      ST_FULL     = 3'd1,
      ST_RELEASED = 3'd2,
      ST_NOT_BUSY = 3'd3,
      ST_BAD_ADDR = 3'd4
   } status_type;

   typedef enum logic {
      ACT_ACQUIRE = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

endpackage

>>> hdl/txbp_req_if.sv
// Request channel of the transmit buffer pool allocator: valid/ready plus payload.
// Depends on txbp_pkg.
interface txbp_req_if;
   import txbp_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] release_address;

   modport source (output valid, action, release_address, input ready);
   modport sink   (input valid, action, release_address, output ready);
endinterface

>>> hdl/txbp_rsp_if.sv
// Response channel of the transmit buffer pool allocator: valid/ready plus payload.
// Depends on txbp_pkg.
interface txbp_rsp_if;
   import txbp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [BUF_IDX_W-1:0]   buffer_index;
   logic [ADDR_W-1:0]      buffer_address;
   logic [IN_FLIGHT_W-1:0] in_flight;

   modport source (output valid, status, buffer_index, buffer_address, in_flight, input ready);
   modport sink   (input valid, status, buffer_index, buffer_address, in_flight, output ready);
endinterface

>>> hdl/txbp_search.sv
// Rotating priority encoder: first free buffer at or after the search pointer.
// No dependencies; purely combinational.
module txbp_search #(
   parameter int unsigned POOL_COUNT = 16,
   parameter int unsigned IDX_W      = $clog2(POOL_COUNT)
) (
   input  logic [POOL_COUNT-1:0] busy,
   input  logic [IDX_W-1:0]      pointer,
   output logic                  found,
   output logic [IDX_W-1:0]      index
);
   logic [POOL_COUNT-1:0] free_all;
   logic [POOL_COUNT-1:0] free_upper;
   logic [IDX_W-1:0]      idx_upper;
   logic [IDX_W-1:0]      idx_all;

   // Free buffers at or above the pointer take priority, then the wrap-around.
   always_comb begin
      free_all  = ~busy;
      idx_upper = '0;
      idx_all   = '0;
      for (int i = 0; i < int'(POOL_COUNT); i++) begin
         free_upper[i] = free_all[i] && (IDX_W'(i) >= pointer);
      end
      for (int i = int'(POOL_COUNT) - 1; i >= 0; i--) begin
         if (free_upper[i]) begin
            idx_upper = IDX_W'(i);
         end
         if (free_all[i]) begin
            idx_all = IDX_W'(i);
         end
      end
      found = |free_all;
      index = (|free_upper) ? idx_upper : idx_all;
   end
endmodule

>>> hdl/txbp_addr_match.sv
// Release address decode: offset from the pool base compared against every buffer boundary.
// Depends on txbp_pkg for the address width; purely combinational.
module txbp_addr_match #(
   parameter int unsigned POOL_COUNT   = 16,
   parameter int unsigned BUFFER_BYTES = 1536,
   parameter int unsigned IDX_W        = $clog2(POOL_COUNT)
) (
   input  logic [txbp_pkg::ADDR_W-1:0] address,
   input  logic [txbp_pkg::ADDR_W-1:0] base,
   output logic                        hit,
   output logic [IDX_W-1:0]            index
);
   import txbp_pkg::*;

   logic [ADDR_W-1:0]     offset;
   logic [POOL_COUNT-1:0] match;

   // An exact hit on a boundary covers both the range and the alignment check,
   // so no divider is needed. At most one boundary can match.
   always_comb begin
      offset = address - base;
      index  = '0;
      for (int i = 0; i < int'(POOL_COUNT); i++) begin
         match[i] = (offset == ADDR_W'(longint'(i) * longint'(BUFFER_BYTES)));
         if (match[i]) begin
            index = IDX_W'(i);
         end
      end
      hit = |match;
   end
endmodule

>>> hdl/txbp_req_stage.sv
// Input register of the allocator: holds one request until the core consumes it.
// Depends on txbp_pkg and txbp_req_if.
module txbp_req_stage (
   input  logic                        clock,
   input  logic                        reset,
   txbp_req_if.sink                    req_if,
   input  logic                        advance,
   output logic                        hold_valid,
   output logic                        hold_action,
   output logic [txbp_pkg::ADDR_W-1:0] hold_address
);
   import txbp_pkg::*;

   logic              valid_ff;
   logic              action_ff;
   logic [ADDR_W-1:0] address_ff;
   logic              take;

   // The slot frees up in the same cycle its request moves to the result register.
   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff  <= req_if.action;
         address_ff <= req_if.release_address;
      end
   end

   assign hold_valid   = valid_ff;
   assign hold_action  = action_ff;
   assign hold_address = address_ff;
endmodule

>>> hdl/tx_buffer_pool_allocator.sv
// Top level of the transmit buffer pool allocator.
// Depends on txbp_pkg, txbp_req_if, txbp_rsp_if, txbp_req_stage, txbp_search, txbp_addr_match.

// The allocator hands out and takes back fixed-size transmit buffers from a pool of
// POOL_COUNT buffers of BUFFER_BYTES bytes each, laid out from the byte address held
// in the pool base register, written through csr_wr_en/csr_wr_data. The user must write it
// only while idle; the block does not enforce this. An acquire request returns the first
// free buffer found by a round-robin search that starts just past the last grant, or
// reports the pool full. A release request names a buffer by address; an address off a
// buffer boundary or outside the pool is reported as bad, a release of a free buffer is
// reported and otherwise ignored. Every request gives exactly one response, which also
// carries the number of busy buffers afterwards. An accepted request waits in the input
// register until the result register is empty or being drained, then moves there; its
// response is taken when the response side is ready. The search and the address decode
// run in one pass between those two registers, and the busy bitmap is updated at the same
// edge, so a new request is accepted every cycle while the response side is ready.
// Nothing needs clearing after reset: the pool is empty as soon as reset is released.
module tx_buffer_pool_allocator #(
   parameter int unsigned POOL_COUNT   = txbp_pkg::POOL_COUNT_DEF,
   parameter int unsigned BUFFER_BYTES = txbp_pkg::BUFFER_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   txbp_req_if.sink                    req_if,
   txbp_rsp_if.source                  rsp_if,
   input  logic                        csr_wr_en,
   input  logic [txbp_pkg::ADDR_W-1:0] csr_wr_data
);
   import txbp_pkg::*;

   localparam int unsigned IDX_W = $clog2(POOL_COUNT);
   localparam int unsigned CNT_W = $clog2(POOL_COUNT + 1);

   // Configuration and allocation state.
   logic [ADDR_W-1:0]     pool_base_ff;
   logic [POOL_COUNT-1:0] busy_ff,    busy_in;
   logic [IDX_W-1:0]      pointer_ff, pointer_in;
   logic [CNT_W-1:0]      count_ff,   count_in;

   // Result register.
   logic                   rsp_valid_ff;
   status_type             status_ff,  status_in;
   logic [IDX_W-1:0]       index_ff,   index_in;
   logic [ADDR_W-1:0]      address_ff, address_in;
   logic [IN_FLIGHT_W-1:0] flight_ff;

   // Held request and per-request results of the two decoders.
   logic              hold_valid;
   logic              hold_action;
   logic [ADDR_W-1:0] hold_address;
   logic              advance;
   logic              step;
   logic              search_found;
   logic [IDX_W-1:0]  search_index;
   logic              match_hit;
   logic [IDX_W-1:0]  match_index;

   // The result register can load whenever it is empty or being drained.
   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign step    = advance && hold_valid;

   txbp_req_stage u_req_stage (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .advance      (advance),
      .hold_valid   (hold_valid),
      .hold_action  (hold_action),
      .hold_address (hold_address)
   );

   txbp_search #(
      .POOL_COUNT (POOL_COUNT),
      .IDX_W      (IDX_W)
   ) u_search (
      .busy    (busy_ff),
      .pointer (pointer_ff),
      .found   (search_found),
      .index   (search_index)
   );

   txbp_addr_match #(
      .POOL_COUNT   (POOL_COUNT),
      .BUFFER_BYTES (BUFFER_BYTES),
      .IDX_W        (IDX_W)
   ) u_addr_match (
      .address (hold_address),
      .base    (pool_base_ff),
      .hit     (match_hit),
      .index   (match_index)
   );

   // One pass over the held request. Unchanged state is the default; only a grant or
   // a release of a busy buffer moves the bitmap and the count.
   always_comb begin
      busy_in    = busy_ff;
      pointer_in = pointer_ff;
      count_in   = count_ff;
      status_in  = ST_FULL;
      index_in   = '0;
      address_in = '0;
      if (hold_action == ACT_ACQUIRE) begin
         if (search_found) begin
            status_in  = ST_GRANTED;
            index_in   = search_index;
            address_in = pool_base_ff + ADDR_W'(BUFFER_BYTES) * ADDR_W'(search_index);
            busy_in    = busy_ff | (POOL_COUNT'(1) << search_index);
            pointer_in = (search_index == IDX_W'(POOL_COUNT - 1)) ? '0 : search_index + 1'b1;
            if (count_ff < CNT_W'(POOL_COUNT)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end else if (!match_hit) begin
         status_in = ST_BAD_ADDR;
      end else begin
         // A hit means the release address is exactly base plus index times size.
         index_in   = match_index;
         address_in = hold_address;
         if (!busy_ff[match_index]) begin
            status_in = ST_NOT_BUSY;
         end else begin
            status_in = ST_RELEASED;
            busy_in   = busy_ff & ~(POOL_COUNT'(1) << match_index);
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
      end else if (csr_wr_en) begin
         pool_base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         pointer_ff <= '0;
         count_ff   <= '0;
      end else if (step) begin
         busy_ff    <= busy_in;
         pointer_ff <= pointer_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= hold_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         status_ff  <= status_in;
         index_ff   <= index_in;
         address_ff <= address_in;
         flight_ff  <= IN_FLIGHT_W'(count_in);
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.buffer_index   = BUF_IDX_W'(index_ff);
   assign rsp_if.buffer_address = address_ff;
   assign rsp_if.in_flight      = flight_ff;
endmodule

>>> hdl/txbp_checker.sv
// Port-level checks for the transmit buffer pool allocator, bound to the top level.
// Depends on txbp_pkg and the assertion macros in tx_buffer_pool_allocator_assert.svh.
`include "tx_buffer_pool_allocator_assert.svh"

module txbp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [txbp_pkg::STATUS_W-1:0]    rsp_status,
   input logic [txbp_pkg::BUF_IDX_W-1:0]   rsp_buffer_index,
   input logic [txbp_pkg::ADDR_W-1:0]      rsp_buffer_address,
   input logic [txbp_pkg::IN_FLIGHT_W-1:0] rsp_in_flight
);
   import txbp_pkg::*;

   // A response left over from before reset must not survive it.
   `TXBP_ASSERT_ALWAYS(a_reset_drops_rsp, reset |=> !rsp_valid, "response valid right after reset")

   // A full pool and a rejected address name no buffer.
   `TXBP_ASSERT(a_full_no_buffer, (rsp_valid && (rsp_status == ST_FULL)) |-> ((rsp_buffer_index == '0) && (rsp_buffer_address == '0)), "pool full response names a buffer")
   `TXBP_ASSERT(a_bad_no_buffer, (rsp_valid && (rsp_status == ST_BAD_ADDR)) |-> ((rsp_buffer_index == '0) && (rsp_buffer_address == '0)), "bad address response names a buffer")

   // A stalled response holds its payload.
   `TXBP_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_buffer_index) && $stable(rsp_buffer_address) && $stable(rsp_in_flight)), "stalled response changed")
endmodule

bind tx_buffer_pool_allocator txbp_checker u_txbp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_buffer_index   (rsp_if.buffer_index),
   .rsp_buffer_address (rsp_if.buffer_address),
   .rsp_in_flight      (rsp_if.in_flight)
);

>>> tb/tx_buffer_pool_allocator_test.sv
// Testbench for the transmit buffer pool allocator: directed and random acquire and
// release requests, with every response checked against an internal model of the pool.
// Depends on txbp_pkg, txbp_req_if, txbp_rsp_if and tx_buffer_pool_allocator.
module tx_buffer_pool_allocator_test;
   import txbp_pkg::*;

   localparam int unsigned SLOTS       = POOL_COUNT_DEF;
   localparam int unsigned SLOT_BYTES  = BUFFER_BYTES_DEF;
   localparam logic [ADDR_W-1:0] POOL_SPAN = ADDR_W'(SLOTS * SLOT_BYTES);
   // The limit leaves a wide margin over the slowest correct run, in which every request
   // may wait out a sender gap and a receiver stall.
   localparam int unsigned CYCLE_LIMIT = 200000;

   // One response as the pool should give it.
   typedef struct packed {
      status_type             status;
      logic [BUF_IDX_W-1:0]   index;
      logic [ADDR_W-1:0]      address;
      logic [IN_FLIGHT_W-1:0] in_flight;
   } alloc_outcome_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [ADDR_W-1:0] csr_wr_data;

   txbp_req_if req_ch ();
   txbp_rsp_if rsp_ch ();

   tx_buffer_pool_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Our own copy of the pool: which buffers are busy, where the next search starts,
   // how many buffers are out, and the base address last written to the register.
   logic [SLOTS-1:0]       shadow_busy;
   logic [BUF_IDX_W-1:0]   shadow_search_ptr;
   logic [IN_FLIGHT_W-1:0] shadow_busy_count;
   logic [ADDR_W-1:0]      shadow_pool_base;

   // Responses still owed by the block, oldest first.
   alloc_outcome_type awaited_outcomes[$];

   int unsigned mismatch_count = 0;
   int unsigned burst_left     = 0;
   int unsigned cycle_count    = 0;
   bit          fill_phase     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Byte address of a buffer, wrapping modulo 2^32 just as a 32-bit adder does.
   function automatic logic [ADDR_W-1:0] slot_address_of(input logic [BUF_IDX_W-1:0] slot);
      return shadow_pool_base + ADDR_W'(slot) * ADDR_W'(SLOT_BYTES);
   endfunction

   // Applies one accepted request to the shadow pool and returns the response that
   // the block must give for it.
   function automatic alloc_outcome_type allocate_or_release(input action_type act,
                                                             input logic [ADDR_W-1:0] addr);
      alloc_outcome_type    res;
      logic [ADDR_W-1:0]    offset;
      logic [BUF_IDX_W-1:0] slot;
      bit                   found;
      res.status  = ST_FULL;
      res.index   = '0;
      res.address = '0;
      found       = 1'b0;
      if (act == ACT_ACQUIRE) begin
         // Round-robin search upward from the pointer; the 4-bit index wraps by itself.
         for (int n = 0; n < SLOTS && !found; n++) begin
            slot = shadow_search_ptr + BUF_IDX_W'(n);
            if (!shadow_busy[slot]) begin
               found             = 1'b1;
               shadow_busy[slot] = 1'b1;
               shadow_search_ptr = slot + 1'b1;
               if (shadow_busy_count < SLOTS) shadow_busy_count++;
               res.status  = ST_GRANTED;
               res.index   = slot;
               res.address = slot_address_of(slot);
            end
         end
      end else begin
         // The offset wraps modulo 2^32, so an address below the base is far out of range.
         offset = addr - shadow_pool_base;
         if (offset >= POOL_SPAN || offset % SLOT_BYTES != 0) begin
            res.status = ST_BAD_ADDR;
         end else begin
            slot        = BUF_IDX_W'(offset / SLOT_BYTES);
            res.index   = slot;
            res.address = slot_address_of(slot);
            if (!shadow_busy[slot]) begin
               res.status = ST_NOT_BUSY;
            end else begin
               shadow_busy[slot] = 1'b0;
               if (shadow_busy_count > 0) shadow_busy_count--;
               res.status = ST_RELEASED;
            end
         end
      end
      res.in_flight = shadow_busy_count;
      return res;
   endfunction

   // Sends one request. The sender works in bursts: at the start of each burst it may
   // drop valid for a random gap; within a burst valid stays high from one request to
   // the next. The expected response is worked out at the edge that accepts the request.
   task automatic send_request(input action_type act, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid           <= 1'b1;
      req_ch.action          <= act;
      req_ch.release_address <= addr;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      awaited_outcomes.push_back(allocate_or_release(act, addr));
   endtask

   // Stops sending and waits until every owed response has come back. Every request
   // gives a response, so once the queue is empty the block holds nothing in flight;
   // the extra wait only covers the two pipeline stages.
   task automatic drain_outstanding();
      req_ch.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The base register is written only while the block is idle.
   task automatic program_pool_base(input logic [ADDR_W-1:0] base);
      drain_outstanding();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= base;
      @(posedge clock);
      shadow_pool_base = base;
      csr_wr_en <= 1'b0;
   endtask

   // Right after reset the pool is empty and the base is zero: a release of buffer 0
   // is ignored, and the top of the address space is not a buffer.
   task automatic test_empty_after_reset();
      send_request(ACT_RELEASE, slot_address_of('0));
      send_request(ACT_RELEASE, 32'hFFFF_FFFF);
   endtask

   // Acquire every buffer in round-robin order, then ask twice more with the pool full.
   task automatic test_fill_to_full();
      for (int n = 0; n < SLOTS + 2; n++) send_request(ACT_ACQUIRE, $urandom());
   endtask

   // Release the last buffer twice (the second one is ignored), try the address just
   // past the pool and one inside a buffer, then free buffer 0 and take it again.
   task automatic test_release_edges();
      send_request(ACT_RELEASE, slot_address_of(BUF_IDX_W'(SLOTS - 1)));
      send_request(ACT_RELEASE, slot_address_of(BUF_IDX_W'(SLOTS - 1)));
      send_request(ACT_RELEASE, shadow_pool_base + POOL_SPAN);
      send_request(ACT_RELEASE, slot_address_of(BUF_IDX_W'(3)) + ADDR_W'(SLOT_BYTES / 2));
      send_request(ACT_RELEASE, slot_address_of('0));
      send_request(ACT_ACQUIRE, $urandom());
   endtask

   // With the base at the top of the address space, buffer addresses wrap through
   // zero, and address zero sits one byte past the base, off a buffer boundary.
   task automatic test_base_at_top();
      program_pool_base(32'hFFFF_FFFF);
      send_request(ACT_ACQUIRE, $urandom());
      send_request(ACT_RELEASE, slot_address_of(BUF_IDX_W'(SLOTS - 1)));
      send_request(ACT_RELEASE, 32'h0000_0000);
   endtask

   // Random traffic under one base setting. The pool swings between filling and
   // draining so that both the full and the empty ends are reached often. Most
   // releases name a busy buffer; some name a random one, and a few are stray
   // addresses: anything at all, inside a buffer, just past the pool, or below the base.
   task automatic test_random_traffic(input logic [ADDR_W-1:0] base,
                                      input int unsigned count);
      int unsigned          pick;
      int unsigned          start;
      logic [BUF_IDX_W-1:0] slot;
      logic [ADDR_W-1:0]    addr;
      program_pool_base(base);
      for (int i = 0; i < count; i++) begin
         if (shadow_busy_count == SLOTS) fill_phase = 1'b0;
         else if (shadow_busy_count == 0) fill_phase = 1'b1;
         else if ($urandom_range(0, 39) == 0) fill_phase = !fill_phase;
         pick = $urandom_range(0, 99);
         if (pick < (fill_phase ? 70 : 25)) begin
            send_request(ACT_ACQUIRE, $urandom());
         end else if (pick < 92) begin
            start = $urandom_range(0, SLOTS - 1);
            slot  = BUF_IDX_W'(start);
            if ($urandom_range(0, 4) != 0) begin
               for (int n = 0; n < SLOTS; n++) begin
                  if (shadow_busy[BUF_IDX_W'(start + n)]) begin
                     slot = BUF_IDX_W'(start + n);
                     break;
                  end
               end
            end
            send_request(ACT_RELEASE, slot_address_of(slot));
         end else begin
            case ($urandom_range(0, 3))
               0: addr = $urandom();
               1: addr = slot_address_of(BUF_IDX_W'($urandom_range(0, SLOTS - 1)))
                         + ADDR_W'($urandom_range(1, SLOT_BYTES - 1));
               2: addr = shadow_pool_base + POOL_SPAN
                         + ADDR_W'($urandom_range(0, 8)) * ADDR_W'(SLOT_BYTES);
               default: addr = shadow_pool_base - ADDR_W'($urandom_range(1, 2 * SLOT_BYTES));
            endcase
            send_request(ACT_RELEASE, addr);
         end
      end
   endtask

   // Response side: checks each accepted response against the oldest expectation,
   // and drives ready on a stall pattern of its own. The pattern switches now and then
   // between always ready, random stalls, alternate cycles, and long holds.
   initial begin : response_checker
      alloc_outcome_type want;
      int unsigned       stall_mode;
      int unsigned       mode_left;
      int unsigned       hold_left;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch($sformatf("response with no request outstanding, status %0d",
                                         rsp_ch.status));
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("status: expected %0d, got %0d",
                                            want.status, rsp_ch.status));
               if (rsp_ch.buffer_index !== want.index)
                  report_mismatch($sformatf("buffer_index: expected %0d, got %0d",
                                            want.index, rsp_ch.buffer_index));
               if (rsp_ch.buffer_address !== want.address)
                  report_mismatch($sformatf("buffer_address: expected %h, got %h",
                                            want.address, rsp_ch.buffer_address));
               if (rsp_ch.in_flight !== want.in_flight)
                  report_mismatch($sformatf("in_flight: expected %0d, got %0d",
                                            want.in_flight, rsp_ch.in_flight));
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 150);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= !rsp_ch.ready;
            default: begin
               if (hold_left == 0) begin
                  rsp_ch.ready <= !rsp_ch.ready;
                  hold_left = $urandom_range(1, 10);
               end else begin
                  hold_left--;
               end
            end
         endcase
      end
   end

   // Main sequence: reset once, the directed cases, then random phases under several
   // base settings, the two extremes among them, and finally the verdict.
   initial begin : main_sequence
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_wr_data            <= '0;
      req_ch.valid           <= 1'b0;
      req_ch.action          <= ACT_ACQUIRE;
      req_ch.release_address <= '0;
      shadow_busy       = '0;
      shadow_search_ptr = '0;
      shadow_busy_count = '0;
      shadow_pool_base  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_after_reset();
      test_fill_to_full();
      test_release_edges();
      test_base_at_top();
      test_random_traffic(32'h0000_0000, 200);
      test_random_traffic(32'hFFFF_C000, 200);
      test_random_traffic($urandom(), 200);
      test_random_traffic(32'hFFFF_FFFF, 200);

      // Wait a bounded time for the last responses, then let the checker run on so that
      // any response the block should not have given is still caught.
      req_ch.valid <= 1'b0;
      for (int w = 0; w < 4000 && awaited_outcomes.size() != 0; w++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (awaited_outcomes.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", awaited_outcomes.size()));

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
